// File: hdl/fstm_pkg.sv
// ----------------------------------------------------------------------------
// fstm_pkg: shared types and constants of the flat span texture mapper
// Item layouts, command codes, register indexes, config port and store sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package fstm_pkg;

    // Item commands
    localparam logic [1:0] CMD_TEXEL = 2'd0;
    localparam logic [1:0] CMD_CMAP  = 2'd1;
    localparam logic [1:0] CMD_DRAW  = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_VIEW_LEFT  = 2'd0;
    localparam logic [1:0] REG_VIEW_TOP   = 2'd1;
    localparam logic [1:0] REG_LOW_DETAIL = 2'd2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Store sizes
    localparam int TILE_DEPTH = 4096;
    localparam int CMAP_DEPTH = 8192;
    localparam int TILE_AW    = 12;
    localparam int CMAP_AW    = 13;

    // Input item
    typedef struct packed {
        logic [1:0]         cmd;
        logic [12:0]        load_addr;
        logic [7:0]         load_data;
        logic signed [31:0] u_start;
        logic signed [31:0] v_start;
        logic signed [31:0] u_step;
        logic signed [31:0] v_step;
        logic [8:0]         first_col;
        logic [8:0]         last_col;
        logic [7:0]         row;
        logic [4:0]         light_level;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0]  colour;
        logic [15:0] fb_address;
        logic        last;
        logic        span_error;
    } t_out_item;

    // View configuration seen by the span walker
    typedef struct packed {
        logic [8:0] view_left;
        logic [7:0] view_top;
        logic       low_detail;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/fstm_ram.sv
// ----------------------------------------------------------------------------
// fstm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/fstm_walker.sv
// ----------------------------------------------------------------------------
// fstm_walker: span sequencer with one shared adder
// Builds the framebuffer address, steps u and v, drives the tile and
// colormap reads and fills the output register one pixel at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fstm_walker #(
    parameter int SCREEN_WIDTH     = 320,
    parameter int MAX_SPAN_RESULTS = 64,
    parameter int LIGHT_LEVELS     = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire fstm_pkg::t_in_item                 i_item,
    input  wire fstm_pkg::t_cfg                     i_cfg,
    output logic                                    o_busy,
    output logic                                    o_tile_rd_en,
    output logic [fstm_pkg::TILE_AW-1:0]            o_tile_rd_addr,
    input  wire logic [7:0]                         i_tile_rd_data,
    output logic                                    o_cmap_rd_en,
    output logic [fstm_pkg::CMAP_AW-1:0]            o_cmap_rd_addr,
    input  wire logic [7:0]                         i_cmap_rd_data,
    output logic                                    o_out_valid,
    output fstm_pkg::t_out_item                     o_out_item,
    input  wire logic                               i_out_stall
);

    localparam int         CNT_W     = $clog2(MAX_SPAN_RESULTS + 1);
    localparam int         MUL_W     = 9 + $clog2(SCREEN_WIDTH + 1);
    localparam logic [4:0] LIGHT_TOP = 5'(LIGHT_LEVELS - 1);
    localparam logic [5:0] LIGHT_LIM = 6'(LIGHT_LEVELS);
    localparam logic [10:0] PIX_LIM  = 11'(MAX_SPAN_RESULTS);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_ROW   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_LEFT  = 4'd4;
    localparam logic [3:0] S_COL   = 4'd5;
    localparam logic [3:0] S_TEX   = 4'd6;
    localparam logic [3:0] S_CMAP  = 4'd7;
    localparam logic [3:0] S_VSTEP = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]       r_state, n_state;
    logic             r_rep;
    logic             r_ld;
    logic [31:0]      r_u, r_v, r_du, r_dv;
    logic [7:0]       r_row;
    logic [9:0]       r_col_off;
    logic [4:0]       r_light;
    logic [15:0]      r_addr;
    logic [CNT_W-1:0] r_pix_cnt, r_pix_total;
    logic             r_out_valid;
    fstm_pkg::t_out_item r_out;

    logic [9:0]       w_texels;
    logic [10:0]      w_pixels;
    logic             w_empty;
    logic             w_too_long;
    logic [4:0]       w_light;
    logic [31:0]      w_op_a, w_op_b, w_sum;
    logic [MUL_W-1:0] w_prod;
    logic             w_out_free;
    logic             w_last_pix;

    // Span length and light clamp, taken when a draw item arrives
    assign w_texels   = {1'b0, i_item.last_col} - {1'b0, i_item.first_col} + 10'd1;
    assign w_pixels   = i_cfg.low_detail ? {w_texels, 1'b0} : {1'b0, w_texels};
    assign w_empty    = i_item.last_col < i_item.first_col;
    assign w_too_long = w_pixels > PIX_LIM;
    assign w_light    = ({1'b0, i_item.light_level} >= LIGHT_LIM) ? LIGHT_TOP
                                                                  : i_item.light_level;

    // Shared adder: operands chosen by the sequencer step
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_state)
            S_ROW: begin
                w_op_a = {24'd0, r_row};
                w_op_b = {24'd0, i_cfg.view_top};
            end
            S_LEFT: begin
                w_op_a = {16'd0, r_addr};
                w_op_b = {23'd0, i_cfg.view_left};
            end
            S_COL: begin
                w_op_a = {16'd0, r_addr};
                w_op_b = {22'd0, r_col_off};
            end
            S_CMAP: begin
                w_op_a = r_u;
                w_op_b = r_du;
            end
            S_VSTEP: begin
                w_op_a = r_v;
                w_op_b = r_dv;
            end
            S_EMIT: begin
                w_op_a = {16'd0, r_addr};
                w_op_b = 32'd1;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end
    assign w_sum = w_op_a + w_op_b;

    // Row times screen width; the row sum sits in the low 9 address bits
    assign w_prod = MUL_W'(r_addr[8:0]) * MUL_W'(SCREEN_WIDTH);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_pix = (r_pix_cnt + CNT_W'(1)) == r_pix_total;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_item.cmd == fstm_pkg::CMD_DRAW) && !w_empty) begin
                    n_state = w_too_long ? S_ERR : S_ROW;
                end
            end
            S_ERR:   n_state = w_out_free ? S_IDLE : S_ERR;
            S_ROW:   n_state = S_MUL;
            S_MUL:   n_state = S_LEFT;
            S_LEFT:  n_state = S_COL;
            S_COL:   n_state = S_TEX;
            S_TEX:   n_state = S_CMAP;
            S_CMAP:  n_state = S_VSTEP;
            S_VSTEP: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    if (w_last_pix) begin
                        n_state = S_IDLE;
                    end else if (r_ld && !r_rep) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_TEX;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (((r_state == S_ERR) || (r_state == S_EMIT)) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_rep <= 1'b0;
            end else if ((r_state == S_EMIT) && w_out_free) begin
                r_rep <= r_ld && !r_rep;
            end
        end
    end

    // Span datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_u         <= i_item.u_start;
                    r_v         <= i_item.v_start;
                    r_du        <= i_item.u_step;
                    r_dv        <= i_item.v_step;
                    r_row       <= i_item.row;
                    r_ld        <= i_cfg.low_detail;
                    r_col_off   <= i_cfg.low_detail ? {i_item.first_col, 1'b0}
                                                    : {1'b0, i_item.first_col};
                    r_light     <= w_light;
                    r_pix_cnt   <= '0;
                    r_pix_total <= w_pixels[CNT_W-1:0];
                end
            end
            S_ROW, S_LEFT, S_COL: r_addr <= w_sum[15:0];
            S_MUL:   r_addr <= w_prod[15:0];
            S_CMAP:  r_u    <= w_sum;
            S_VSTEP: r_v    <= w_sum;
            S_EMIT: begin
                if (w_out_free) begin
                    r_addr    <= w_sum[15:0];
                    r_pix_cnt <= r_pix_cnt + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_ERR) && w_out_free) begin
            r_out <= '{colour: 8'd0, fb_address: 16'd0, last: 1'b1, span_error: 1'b1};
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out <= '{colour: i_cmap_rd_data, fb_address: r_addr,
                       last: w_last_pix, span_error: 1'b0};
        end
    end

    // Store reads: tile row from v, column from u; colormap by light and texel
    assign o_tile_rd_en   = r_state == S_TEX;
    assign o_tile_rd_addr = {r_v[21:16], r_u[21:16]};
    assign o_cmap_rd_en   = r_state == S_CMAP;
    assign o_cmap_rd_addr = {r_light, i_tile_rd_data};

    assign o_busy      = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: hdl/flat_span_texture_mapper_unit.sv
// ----------------------------------------------------------------------------
// flat_span_texture_mapper_unit: affine span texture mapper, 64x64 tile
// Top level: config registers, texture tile and colormap stores, span walker.
// ----------------------------------------------------------------------------
// Load items (texel or colormap entry) are written into their store as they
// are taken and never stall the input. A draw item keeps the input stalled
// after it is taken until its last pixel leaves, longer while the output side
// stalls: four setup steps build the framebuffer address (the row, left-edge
// and column adds on the single shared adder, the screen-width multiply apart
// from it), then each texel costs a tile read, a colormap read and a u/v step
// on that adder before its pixel leaves (two pixels in low detail). An empty
// span leaves the input free on the next cycle; a span over the result limit
// stalls it until its error result can enter the output register. Both
// stores power up undefined and must be loaded before they are drawn from.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_span_texture_mapper_unit #(
    parameter int SCREEN_WIDTH     = 320,
    parameter int MAX_SPAN_RESULTS = 64,
    parameter int LIGHT_LEVELS     = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input items
    input  wire logic                            i_in_valid,
    input  wire fstm_pkg::t_in_item              i_in_item,
    output logic                                 o_in_stall,
    // Result items
    output logic                                 o_out_valid,
    output fstm_pkg::t_out_item                  o_out_item,
    input  wire logic                            i_out_stall,
    // Configuration port
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [fstm_pkg::PADDR_W-1:0]    i_paddr,
    input  wire logic [fstm_pkg::PDATA_W-1:0]    i_pwdata,
    output logic      [fstm_pkg::PDATA_W-1:0]    o_prdata,
    output logic                                 o_pready
);

    fstm_pkg::t_cfg r_cfg;

    logic                           w_accept;
    logic                           w_busy;
    logic                           w_cfg_wr;
    logic [1:0]                     w_reg_idx;
    logic                           w_tile_rd_en, w_cmap_rd_en;
    logic [fstm_pkg::TILE_AW-1:0]   w_tile_rd_addr;
    logic [fstm_pkg::CMAP_AW-1:0]   w_cmap_rd_addr;
    logic [7:0]                     w_tile_rd_data, w_cmap_rd_data;

    // Configuration registers
    assign o_pready  = 1'b1;
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite;
    assign w_reg_idx = i_paddr[fstm_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                fstm_pkg::REG_VIEW_LEFT:  r_cfg.view_left  <= i_pwdata[8:0];
                fstm_pkg::REG_VIEW_TOP:   r_cfg.view_top   <= i_pwdata[7:0];
                fstm_pkg::REG_LOW_DETAIL: r_cfg.low_detail <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            fstm_pkg::REG_VIEW_LEFT:  o_prdata = {23'd0, r_cfg.view_left};
            fstm_pkg::REG_VIEW_TOP:   o_prdata = {24'd0, r_cfg.view_top};
            fstm_pkg::REG_LOW_DETAIL: o_prdata = {31'd0, r_cfg.low_detail};
            default:                  o_prdata = '0;
        endcase
    end

    // Input handshake: one item at a time
    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    // Texture tile, loaded by texel items
    fstm_ram #(
        .WIDTH (8),
        .DEPTH (fstm_pkg::TILE_DEPTH)
    ) u_tile (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_in_item.cmd == fstm_pkg::CMD_TEXEL)),
        .i_wr_addr (i_in_item.load_addr[fstm_pkg::TILE_AW-1:0]),
        .i_wr_data (i_in_item.load_data),
        .i_rd_en   (w_tile_rd_en),
        .i_rd_addr (w_tile_rd_addr),
        .o_rd_data (w_tile_rd_data)
    );

    // Light colormaps, loaded by colormap items
    fstm_ram #(
        .WIDTH (8),
        .DEPTH (fstm_pkg::CMAP_DEPTH)
    ) u_cmap (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_in_item.cmd == fstm_pkg::CMD_CMAP)),
        .i_wr_addr (i_in_item.load_addr),
        .i_wr_data (i_in_item.load_data),
        .i_rd_en   (w_cmap_rd_en),
        .i_rd_addr (w_cmap_rd_addr),
        .o_rd_data (w_cmap_rd_data)
    );

    // Span walker
    fstm_walker #(
        .SCREEN_WIDTH     (SCREEN_WIDTH),
        .MAX_SPAN_RESULTS (MAX_SPAN_RESULTS),
        .LIGHT_LEVELS     (LIGHT_LEVELS)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_accept),
        .i_item         (i_in_item),
        .i_cfg          (r_cfg),
        .o_busy         (w_busy),
        .o_tile_rd_en   (w_tile_rd_en),
        .o_tile_rd_addr (w_tile_rd_addr),
        .i_tile_rd_data (w_tile_rd_data),
        .o_cmap_rd_en   (w_cmap_rd_en),
        .o_cmap_rd_addr (w_cmap_rd_addr),
        .i_cmap_rd_data (w_cmap_rd_data),
        .o_out_valid    (o_out_valid),
        .o_out_item     (o_out_item),
        .i_out_stall    (i_out_stall)
    );

endmodule

`default_nettype wire

// File: hdl/fstm_checker.sv
// ----------------------------------------------------------------------------
// fstm_checker: port-level checks for the flat span texture mapper
// Watches the top level's handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fstm_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire fstm_pkg::t_in_item  i_in_item,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire fstm_pkg::t_out_item o_out_item,
    input wire logic                i_out_stall
);

    logic w_in_acc;
    logic w_is_load;
    logic w_is_draw;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_is_load = (i_in_item.cmd == fstm_pkg::CMD_TEXEL) ||
                       (i_in_item.cmd == fstm_pkg::CMD_CMAP);
    assign w_is_draw = i_in_item.cmd == fstm_pkg::CMD_DRAW;

    // A load item never holds up the next item
    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_is_load |=> !o_in_stall)
        else $error("input stalled after a load item");

    // An empty span leaves the block ready at once
    a_empty_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_is_draw && (i_in_item.last_col < i_in_item.first_col)
        |=> !o_in_stall)
        else $error("input stalled after an empty span");

    // A non-empty span occupies the block for at least the next cycle
    a_span_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_is_draw && (i_in_item.last_col >= i_in_item.first_col)
        |=> o_in_stall)
        else $error("span accepted without occupying the block");

    // An error result is the whole span: last set, payload cleared
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.span_error
        |-> o_out_item.last && (o_out_item.colour == 8'd0) &&
            (o_out_item.fb_address == 16'd0))
        else $error("malformed span error result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind flat_span_texture_mapper_unit fstm_checker u_fstm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
